/* hw/rtl/bpcd_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package bpcd_pkg;

    // Item function codes; code 3 carries no meaning and is ignored.
    typedef enum logic [1:0] {
        FUNC_POLL   = 2'd0,
        FUNC_START  = 2'd1,
        FUNC_CANCEL = 2'd2
    } func_t;

    // Presence events reported with each result.
    typedef enum logic [2:0] {
        EV_NONE      = 3'd0,
        EV_STARTED   = 3'd1,
        EV_DONE      = 3'd2,
        EV_TIMEOUT   = 3'd3,
        EV_CANCELLED = 3'd4
    } event_t;

    // Configuration register indexes.
    localparam int unsigned CFG_INDEX_W = 3;
    localparam logic [CFG_INDEX_W-1:0] CFG_FORCE_WAIT      = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_CLICK_ENABLE    = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_DEFAULT_TIMEOUT = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_PRESSED_LIMIT   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_CLICK_WINDOW    = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_POLL_INTERVAL   = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] CFG_BOOT_DELAY      = 3'd6;

    // Register values after reset.
    localparam logic [31:0] RST_DEFAULT_TIMEOUT = 32'd30000;
    localparam logic [31:0] RST_PRESSED_LIMIT   = 32'd15000;
    localparam logic [31:0] RST_CLICK_WINDOW    = 32'd1000;
    localparam logic [31:0] RST_POLL_INTERVAL   = 32'd10;
    localparam logic [31:0] RST_BOOT_DELAY      = 32'd1000;

    localparam logic [31:0] MS_PER_SECOND = 32'd1000;

    // Current configuration as seen by the core.
    typedef struct packed {
        logic        force_wait;
        logic        click_enable;
        logic [31:0] default_timeout;
        logic [31:0] pressed_limit;
        logic [31:0] click_window;
        logic [31:0] poll_interval;
        logic [31:0] boot_delay;
    } cfg_t;

    // One input item.
    typedef struct packed {
        logic [1:0]  func;
        logic [31:0] now_ms;
        logic        level;
        logic        busy;
        logic [22:0] tsec;
    } item_t;

    // Result of one item leaving the core; ms_sel is the timeout in ms of a start.
    typedef struct packed {
        event_t      event_code;
        logic        pending;
        logic        taken;
        logic [7:0]  clicks;
        logic [31:0] hold_ms;
        logic [31:0] ms_sel;
    } result_t;

endpackage : bpcd_pkg

`default_nettype wire

/* hw/rtl/bpcd_cfg.sv */
`timescale 1ns / 1ps
`default_nettype none

module bpcd_cfg
    import bpcd_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_write,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [31:0]            cfg_data,
    output cfg_t                        cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Decode a register write; indexes beyond the list are dropped.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                CFG_FORCE_WAIT:      cfg_next.force_wait      = cfg_data[0];
                CFG_CLICK_ENABLE:    cfg_next.click_enable    = cfg_data[0];
                CFG_DEFAULT_TIMEOUT: cfg_next.default_timeout = cfg_data;
                CFG_PRESSED_LIMIT:   cfg_next.pressed_limit   = cfg_data;
                CFG_CLICK_WINDOW:    cfg_next.click_window    = cfg_data;
                CFG_POLL_INTERVAL:   cfg_next.poll_interval   = cfg_data;
                CFG_BOOT_DELAY:      cfg_next.boot_delay      = cfg_data;
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    // Register bank with its reset values.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.force_wait      <= 1'b0;
            cfg_reg.click_enable    <= 1'b0;
            cfg_reg.default_timeout <= RST_DEFAULT_TIMEOUT;
            cfg_reg.pressed_limit   <= RST_PRESSED_LIMIT;
            cfg_reg.click_window    <= RST_CLICK_WINDOW;
            cfg_reg.poll_interval   <= RST_POLL_INTERVAL;
            cfg_reg.boot_delay      <= RST_BOOT_DELAY;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule : bpcd_cfg

`default_nettype wire

/* hw/rtl/bpcd_core.sv */
`timescale 1ns / 1ps
`default_nettype none

module bpcd_core
    import bpcd_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  fire,
    input  wire item_t item,
    input  wire cfg_t  cfg,
    output result_t    result
);

    localparam logic [7:0] CLICK_MAX = 8'hFF;

    // Block state.
    logic        wait_active_reg,     wait_active_next;
    logic        wait_seen_reg,       wait_seen_next;
    logic [31:0] wait_start_reg,      wait_start_next;
    logic [31:0] wait_timeout_reg,    wait_timeout_next;
    logic        cancel_pending_reg,  cancel_pending_next;
    logic [31:0] last_poll_reg,       last_poll_next;
    logic        hold_level_reg,      hold_level_next;
    logic [31:0] hold_start_reg,      hold_start_next;
    logic [31:0] hold_duration_reg,   hold_duration_next;
    logic        click_level_reg,     click_level_next;
    logic [31:0] click_last_reg,      click_last_next;
    logic [7:0]  click_counter_reg,   click_counter_next;

    logic        poll_ok;
    logic        seen;
    logic        wait_expired;
    logic [31:0] wait_end;
    logic [31:0] pressed_end;
    logic [31:0] start_ms;
    logic [31:0] click_old_end;
    logic [31:0] click_new_end;
    logic        click_level_mid;
    logic [31:0] click_last_mid;
    logic [7:0]  click_counter_mid;
    logic        click_report;
    event_t      wait_event;

    // Sample gating: past the boot delay, poll interval elapsed, waiting or not busy.
    assign poll_ok = (item.now_ms > cfg.boot_delay)
                  && ((item.now_ms - last_poll_reg) >= cfg.poll_interval)
                  && (wait_active_reg || !item.busy);

    // Wait timing; sums wrap at 32 bits.
    assign seen         = wait_seen_reg | item.level;
    assign wait_end     = wait_start_reg + wait_timeout_reg;
    assign pressed_end  = wait_start_reg + cfg.pressed_limit;
    assign wait_expired = (wait_end < item.now_ms) || (seen && (pressed_end < item.now_ms));

    // Event of a sample taken during a wait.
    always_comb
    begin
        if (cancel_pending_reg)
        begin
            wait_event = EV_CANCELLED;
        end
        else if (wait_expired)
        begin
            wait_event = EV_TIMEOUT;
        end
        else if (seen && !item.level)
        begin
            wait_event = EV_DONE;
        end
        else
        begin
            wait_event = EV_NONE;
        end
    end

    // Requested timeout in ms, truncated to 32 bits.
    assign start_ms = {9'd0, item.tsec} * MS_PER_SECOND;

    // Click tracking on an edge of the level; a release counts within the window.
    assign click_old_end = click_last_reg + cfg.click_window;

    always_comb
    begin
        click_level_mid   = click_level_reg;
        click_last_mid    = click_last_reg;
        click_counter_mid = click_counter_reg;
        if (item.level != click_level_reg)
        begin
            if (!item.level)
            begin
                if ((click_last_reg == 32'd0) || (click_old_end > item.now_ms))
                begin
                    if (click_counter_reg != CLICK_MAX)
                    begin
                        click_counter_mid = click_counter_reg + 8'd1;
                    end
                end
                click_last_mid = item.now_ms;
            end
            click_level_mid = item.level;
        end
    end

    // A burst is reported once its window has lapsed with the button up.
    assign click_new_end = click_last_mid + cfg.click_window;
    assign click_report  = (click_last_mid != 32'd0) && (click_counter_mid != 8'd0)
                        && (click_new_end < item.now_ms) && !click_level_mid;

    // Next state and result of the item.
    always_comb
    begin
        wait_active_next    = wait_active_reg;
        wait_seen_next      = wait_seen_reg;
        wait_start_next     = wait_start_reg;
        wait_timeout_next   = wait_timeout_reg;
        cancel_pending_next = cancel_pending_reg;
        last_poll_next      = last_poll_reg;
        hold_level_next     = hold_level_reg;
        hold_start_next     = hold_start_reg;
        hold_duration_next  = hold_duration_reg;
        click_level_next    = click_level_reg;
        click_last_next     = click_last_reg;
        click_counter_next  = click_counter_reg;

        result.event_code = EV_NONE;
        result.taken      = 1'b0;
        result.clicks     = 8'd0;
        result.ms_sel     = start_ms;

        case (func_t'(item.func))
            FUNC_POLL:
            begin
                if (poll_ok)
                begin
                    result.taken   = 1'b1;
                    last_poll_next = item.now_ms;
                    if (wait_active_reg)
                    begin
                        wait_seen_next    = seen;
                        result.event_code = wait_event;
                        if (wait_event != EV_NONE)
                        begin
                            wait_active_next = 1'b0;
                        end
                    end
                    else
                    begin
                        // Hold duration measurement.
                        if (item.level && !hold_level_reg)
                        begin
                            hold_start_next    = item.now_ms;
                            hold_duration_next = 32'd0;
                        end
                        else if (!item.level && hold_level_reg)
                        begin
                            hold_duration_next = item.now_ms - hold_start_reg;
                            hold_start_next    = 32'd0;
                        end
                        else if (item.level && hold_level_reg)
                        begin
                            hold_duration_next = item.now_ms - hold_start_reg;
                        end
                        hold_level_next = item.level;

                        if (cfg.click_enable)
                        begin
                            click_level_next   = click_level_mid;
                            click_last_next    = click_last_mid;
                            click_counter_next = click_counter_mid;
                            if (click_report)
                            begin
                                result.clicks      = click_counter_mid;
                                click_last_next    = 32'd0;
                                click_counter_next = 8'd0;
                            end
                        end
                    end
                end
            end
            FUNC_START:
            begin
                // A zero request ends at once unless force_wait selects the default timeout.
                if ((item.tsec == 23'd0) && !cfg.force_wait)
                begin
                    result.event_code = EV_DONE;
                end
                else
                begin
                    if (item.tsec == 23'd0)
                    begin
                        result.ms_sel = cfg.default_timeout;
                    end
                    result.event_code   = EV_STARTED;
                    cancel_pending_next = 1'b0;
                    wait_active_next    = 1'b1;
                    wait_seen_next      = item.level;
                    wait_start_next     = item.now_ms;
                    wait_timeout_next   = result.ms_sel;
                end
            end
            FUNC_CANCEL:
            begin
                cancel_pending_next = 1'b1;
            end
            default:
            begin
                result.event_code = EV_NONE;
            end
        endcase

        result.pending = wait_active_next;
        result.hold_ms = hold_duration_next;
    end

    // State update on each item passing through.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wait_active_reg    <= 1'b0;
            wait_seen_reg      <= 1'b0;
            wait_start_reg     <= 32'd0;
            wait_timeout_reg   <= 32'd0;
            cancel_pending_reg <= 1'b0;
            last_poll_reg      <= 32'd0;
            hold_level_reg     <= 1'b0;
            hold_start_reg     <= 32'd0;
            hold_duration_reg  <= 32'd0;
            click_level_reg    <= 1'b0;
            click_last_reg     <= 32'd0;
            click_counter_reg  <= 8'd0;
        end
        else if (fire)
        begin
            wait_active_reg    <= wait_active_next;
            wait_seen_reg      <= wait_seen_next;
            wait_start_reg     <= wait_start_next;
            wait_timeout_reg   <= wait_timeout_next;
            cancel_pending_reg <= cancel_pending_next;
            last_poll_reg      <= last_poll_next;
            hold_level_reg     <= hold_level_next;
            hold_start_reg     <= hold_start_next;
            hold_duration_reg  <= hold_duration_next;
            click_level_reg    <= click_level_next;
            click_last_reg     <= click_last_next;
            click_counter_reg  <= click_counter_next;
        end
    end

endmodule : bpcd_core

`default_nettype wire

/* hw/rtl/button_presence_and_click_detector.sv */
`timescale 1ns / 1ps
`default_nettype none

// Button presence and multi-click detector.
// Input channel: in_valid with func, now_ms, button_level, system_busy and
// wait_timeout_s; a transfer happens on a clock edge with in_valid high and
// in_stall low. Every input transfer yields exactly one result on the output
// channel (out_valid, out_stall), in order.
// Configuration: cfg_write with cfg_index and cfg_data writes one register
// at the clock edge; it is meant to be used only while no item is in flight.
// Pipeline: an item passes an input register, the state update stage and the
// seconds conversion stage before its result is presented. While out_stall
// is low the block accepts one item per cycle; the state update of the middle
// stage is combinational and registered as the item moves on, which lets the
// next item follow directly.
// When out_stall is held the three stages fill up and in_stall rises once all
// of them hold an item; nothing is dropped and the shown result holds.
// Reset (rst_n low, asynchronous) empties the stages, clears all wait, hold
// and click state and loads the registers with their default values.

module button_presence_and_click_detector
    import bpcd_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_write,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [31:0]            cfg_data,
    input  wire logic                   in_valid,
    output logic                        in_stall,
    input  wire logic [1:0]             func,
    input  wire logic [31:0]            now_ms,
    input  wire logic                   button_level,
    input  wire logic                   system_busy,
    input  wire logic [22:0]            wait_timeout_s,
    output logic                        out_valid,
    input  wire logic                   out_stall,
    output logic [2:0]                  presence_event,
    output logic [22:0]                 request_timeout_s,
    output logic                        wait_pending,
    output logic                        sample_taken,
    output logic [7:0]                  click_count,
    output logic [31:0]                 hold_duration_ms
);

    // Reciprocal of 125 for 29-bit dividends: ms / 1000 = ((ms >> 3) * RECIP) >> 36.
    localparam int unsigned DIV_SHIFT = 36;
    localparam logic [29:0] RECIP_125 = 30'd549755814;

    cfg_t        cfg;
    item_t       in_item_reg;
    logic        in_valid_reg;
    result_t     core_result;
    result_t     mid_reg;
    logic        mid_valid_reg;
    logic        out_valid_reg;
    event_t      out_event_reg;
    logic [22:0] out_req_reg;
    logic        out_pending_reg;
    logic        out_taken_reg;
    logic [7:0]  out_clicks_reg;
    logic [31:0] out_hold_reg;

    logic        out_ready;
    logic        mid_ready;
    logic        in_ready;
    logic        core_fire;
    logic [58:0] div_product;
    logic [22:0] req_seconds;

    // Stage handshake: each stage moves on when the one after it has room.
    assign out_ready = !out_valid_reg || !out_stall;
    assign mid_ready = !mid_valid_reg || out_ready;
    assign in_ready  = !in_valid_reg || mid_ready;
    assign core_fire = in_valid_reg && mid_ready;
    assign in_stall  = !in_ready;

    bpcd_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            in_item_reg.func   <= func;
            in_item_reg.now_ms <= now_ms;
            in_item_reg.level  <= button_level;
            in_item_reg.busy   <= system_busy;
            in_item_reg.tsec   <= wait_timeout_s;
        end
    end

    bpcd_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (core_fire),
        .item   (in_item_reg),
        .cfg    (cfg),
        .result (core_result)
    );

    // Result of the state update.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mid_valid_reg <= 1'b0;
        end
        else if (mid_ready)
        begin
            mid_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (core_fire)
        begin
            mid_reg <= core_result;
        end
    end

    // Announced timeout in whole seconds.
    assign div_product = {30'd0, mid_reg.ms_sel[31:3]} * {29'd0, RECIP_125};
    assign req_seconds = (mid_reg.event_code == EV_STARTED)
                       ? div_product[DIV_SHIFT+22:DIV_SHIFT] : 23'd0;

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_ready)
        begin
            out_valid_reg <= mid_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_ready && mid_valid_reg)
        begin
            out_event_reg   <= mid_reg.event_code;
            out_req_reg     <= req_seconds;
            out_pending_reg <= mid_reg.pending;
            out_taken_reg   <= mid_reg.taken;
            out_clicks_reg  <= mid_reg.clicks;
            out_hold_reg    <= mid_reg.hold_ms;
        end
    end

    assign out_valid         = out_valid_reg;
    assign presence_event    = out_event_reg;
    assign request_timeout_s = out_req_reg;
    assign wait_pending      = out_pending_reg;
    assign sample_taken      = out_taken_reg;
    assign click_count       = out_clicks_reg;
    assign hold_duration_ms  = out_hold_reg;

`ifndef NO_ASSERTIONS
    // A started wait is still pending when its result leaves.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (presence_event == EV_STARTED) |-> wait_pending)
        else $error("started event without a pending wait");

    // Timeout and cancel end a wait and come only from a taken sample.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && ((presence_event == EV_TIMEOUT) || (presence_event == EV_CANCELLED))
        |-> (sample_taken && !wait_pending))
        else $error("timeout or cancel without an ended wait");

    // A click report comes from an idle sample and carries no presence event.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (click_count != 8'd0)
        |-> (sample_taken && (presence_event == EV_NONE) && !wait_pending))
        else $error("click report outside an idle sample");

    // Only a start announces a timeout.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (presence_event != EV_STARTED) |-> (request_timeout_s == 23'd0))
        else $error("timeout announced without a start");
`endif

endmodule : button_presence_and_click_detector

`default_nettype wire
